// ----- hdl/lkvc_pkg.sv -----
// ---------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants for the lru key-value cache.
// ---------------------------------------------------------------------------
`default_nettype none

package lkvc_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  localparam logic [VAL_W-1:0] MISS_VALUE = '1;

  // controller to datapath
  typedef struct packed {
    logic load;      // latch the incoming word, clear scan trackers
    logic scan_rd;   // read key, value and rank at the sweep address
    logic respond;   // commit the result and the key/value write
    logic upd_rd;    // read rank at the sweep address for the rank pass
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_update;  // ranks must be reworked after this word
  } sts_t;

endpackage

`default_nettype wire

// ----- hdl/lkvc_ctrl.sv -----
// ---------------------------------------------------------------------------
// lkvc_ctrl
// Sequencer: tag sweep, response, then on a hit or insert a rank rework pass over all entries.
// ---------------------------------------------------------------------------
`default_nettype none

module lkvc_ctrl import lkvc_pkg::*; #(
  parameter int ENTRIES = 16,
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output      logic          busy,
  input  wire sts_t          sts,
  output      cmd_t          cmd,
  output      logic [AW-1:0] addr
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_SFIN = 3'd2;
  localparam logic [2:0] S_RESP = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;
  localparam logic [2:0] S_UFIN = 3'd5;

  localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

  logic [2:0]    state;
  logic [2:0]    state_next;
  logic [AW-1:0] cnt;
  logic [AW-1:0] cnt_next;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (cnt == LAST) begin
          cnt_next   = '0;
          state_next = S_SFIN;
        end else begin
          cnt_next = cnt + AW'(1);
        end
      end
      // last read data is evaluated here
      S_SFIN: state_next = S_RESP;
      S_RESP: begin
        cmd.respond = 1'b1;
        state_next  = sts.need_update ? S_UPD : S_IDLE;
      end
      S_UPD: begin
        cmd.upd_rd = 1'b1;
        if (cnt == LAST) begin
          cnt_next   = '0;
          state_next = S_UFIN;
        end else begin
          cnt_next = cnt + AW'(1);
        end
      end
      // last rank write lands here
      S_UFIN: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  assign busy = (state != S_IDLE);
  assign addr = cnt;

endmodule

`default_nettype wire

// ----- hdl/lkvc_dp.sv -----
// ---------------------------------------------------------------------------
// lkvc_dp
// Entry storage, valid bits, occupancy, sweep trackers and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module lkvc_dp import lkvc_pkg::*; #(
  parameter int ENTRIES = 16,
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int OW = $clog2(ENTRIES + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cmd_t             cmd,
  input  wire logic [AW-1:0]    addr,
  output      sts_t             sts,
  input  wire logic             operation,
  input  wire logic [KEY_W-1:0] key,
  input  wire logic [VAL_W-1:0] value,
  input  wire logic             write_enable,
  input  wire logic [CAP_W-1:0] write_data,
  output      logic             done,
  output      logic             found,
  output      logic [VAL_W-1:0] read_value,
  output      logic             evicted,
  output      logic [KEY_W-1:0] evicted_key
);

  // memories
  logic [KEY_W-1:0] key_mem  [ENTRIES];
  logic [VAL_W-1:0] val_mem  [ENTRIES];
  logic [AW-1:0]    rank_mem [ENTRIES];
  logic [KEY_W-1:0] key_rd;
  logic [VAL_W-1:0] val_rd;
  logic [AW-1:0]    rank_rd;

  logic [ENTRIES-1:0] valid;
  logic [OW-1:0]      occ;
  logic [CAP_W-1:0]   capacity;

  logic             op_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] value_q;

  logic          scan_q;
  logic          upd_q;
  logic [AW-1:0] addr_q;

  // sweep trackers
  logic             hit_q;
  logic [AW-1:0]    hit_addr;
  logic [AW-1:0]    hit_rank;
  logic [VAL_W-1:0] hit_val;
  logic             lru_any;
  logic [AW-1:0]    lru_addr;
  logic [AW-1:0]    lru_rank;
  logic [KEY_W-1:0] lru_key;
  logic             free_any;
  logic [AW-1:0]    free_addr;

  // rank pass context
  logic [AW-1:0] slot_q;
  logic [AW-1:0] old_rank_q;
  logic          ins_q;

  logic             cur_valid;
  logic [CAP_W-1:0] cap_eff;
  logic             full;
  logic             do_evict;
  logic             do_insert;
  logic [AW-1:0]    slot_sel;
  logic             rank_we;
  logic [AW-1:0]    rank_wd;

  assign cur_valid = valid[addr_q];

  assign cap_eff   = (capacity == '0) ? CAP_W'(1) : capacity;
  assign full      = (32'(occ) >= 32'(ENTRIES)) || (32'(occ) >= 32'(cap_eff));
  assign do_evict  = !hit_q && (op_q == OP_PUT) && full && lru_any;
  assign do_insert = !hit_q && (op_q == OP_PUT) && (do_evict || free_any);
  assign slot_sel  = hit_q ? hit_addr : (do_evict ? lru_addr : free_addr);

  assign sts.need_update = hit_q || do_insert;

  // memory reads share the sweep address
  always_ff @(posedge clk) begin
    if (cmd.scan_rd) begin
      key_rd <= key_mem[addr];
      val_rd <= val_mem[addr];
    end
    if (cmd.scan_rd || cmd.upd_rd) begin
      rank_rd <= rank_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.respond && do_insert) begin
      key_mem[slot_sel] <= key_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.respond && (do_insert || (hit_q && op_q == OP_PUT))) begin
      val_mem[slot_sel] <= value_q;
    end
  end

  // the promoted or inserted slot goes to rank zero; on a hit the newer ones age by one, on an insert all others do
  always_comb begin
    rank_we = 1'b0;
    rank_wd = '0;
    if (upd_q) begin
      if (addr_q == slot_q) begin
        rank_we = 1'b1;
      end else if (cur_valid && (ins_q || rank_rd < old_rank_q)) begin
        rank_we = 1'b1;
        rank_wd = rank_rd + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rank_we) begin
      rank_mem[addr_q] <= rank_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_q <= 1'b0;
      upd_q  <= 1'b0;
    end else begin
      scan_q <= cmd.scan_rd;
      upd_q  <= cmd.upd_rd;
    end
    addr_q <= addr;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q     <= operation;
      key_q    <= key;
      value_q  <= value;
      hit_q    <= 1'b0;
      lru_any  <= 1'b0;
      free_any <= 1'b0;
    end else if (scan_q) begin
      if (cur_valid && !hit_q && key_rd == key_q) begin
        hit_q    <= 1'b1;
        hit_addr <= addr_q;
        hit_rank <= rank_rd;
        hit_val  <= val_rd;
      end
      if (cur_valid && (!lru_any || rank_rd > lru_rank)) begin
        lru_any  <= 1'b1;
        lru_addr <= addr_q;
        lru_rank <= rank_rd;
        lru_key  <= key_rd;
      end
      if (!cur_valid && !free_any) begin
        free_any  <= 1'b1;
        free_addr <= addr_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      occ      <= '0;
      capacity <= CAP_RESET;
    end else if (write_enable) begin
      valid    <= '0;
      occ      <= '0;
      capacity <= write_data;
    end else if (cmd.respond && do_insert) begin
      valid[slot_sel] <= 1'b1;
      if (!do_evict) begin
        occ <= occ + OW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.respond;
    end
    if (cmd.respond) begin
      found       <= hit_q;
      evicted     <= do_evict;
      evicted_key <= do_evict ? lru_key : '0;
      if (op_q == OP_PUT) begin
        read_value <= '0;
      end else begin
        read_value <= hit_q ? hit_val : MISS_VALUE;
      end
      slot_q     <= slot_sel;
      old_rank_q <= hit_rank;
      ins_q      <= !hit_q;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/lru_key_value_cache_top.sv -----
// ---------------------------------------------------------------------------
// lru_key_value_cache_top
// Fully associative key-value cache with least-recently-used replacement.
// ---------------------------------------------------------------------------
// A word (operation, key, value) is taken when start is high and busy is low.
// operation selects get or put. The result (found, read_value, evicted,
// evicted_key) appears for one cycle with done high; the receiver cannot
// stall, so it must take the word in that cycle.
// Each word first sweeps all ENTRIES slots through one read port of the
// key, value and rank memories, one slot a cycle; done rises after that
// sweep. A hit or an insert then runs a second sweep that rewrites the
// recency ranks, one slot a cycle, and busy stays high until it ends; a
// get miss runs no second sweep. The next word can be accepted as soon as
// busy is low. capacity is written through write_enable / write_data; the
// user must do so only while busy is low, which the block does not enforce.
// Each write empties the cache. Reset empties the cache and sets capacity
// to 16. No clearing pass is needed: valid bits are flip-flops.
// ---------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache_top import lkvc_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output      logic             busy,
  input  wire logic             operation,
  input  wire logic [KEY_W-1:0] key,
  input  wire logic [VAL_W-1:0] value,
  input  wire logic             write_enable,
  input  wire logic [CAP_W-1:0] write_data,
  output      logic             done,
  output      logic             found,
  output      logic [VAL_W-1:0] read_value,
  output      logic             evicted,
  output      logic [KEY_W-1:0] evicted_key
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  cmd_t          cmd;
  sts_t          sts;
  logic [AW-1:0] addr;

  lkvc_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd),
    .addr  (addr)
  );

  lkvc_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .addr         (addr),
    .sts          (sts),
    .operation    (operation),
    .key          (key),
    .value        (value),
    .write_enable (write_enable),
    .write_data   (write_data),
    .done         (done),
    .found        (found),
    .read_value   (read_value),
    .evicted      (evicted),
    .evicted_key  (evicted_key)
  );

endmodule

`default_nettype wire

// ----- hdl/lkvc_checker.sv -----
// ---------------------------------------------------------------------------
// lkvc_checker
// Port-level checks on the cache, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module lkvc_checker import lkvc_pkg::*; (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             start,
  input wire logic             busy,
  input wire logic             done,
  input wire logic             found,
  input wire logic             evicted,
  input wire logic [KEY_W-1:0] evicted_key
);

  // a taken word keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  // a result only follows work in progress
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a word in flight");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held two cycles");

  // a hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    done |-> !(found && evicted))
    else $error("eviction reported on a hit");

  a_evkey_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !evicted) |-> (evicted_key == '0))
    else $error("evicted key nonzero without eviction");

endmodule

bind lru_key_value_cache_top lkvc_checker u_lkvc_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .found       (found),
  .evicted     (evicted),
  .evicted_key (evicted_key)
);

`default_nettype wire
